// ===== hw/rtl/dcpc_pkg.sv =====
// Package for the depth to colored point cloud block: shared types, widths,
// register indexes and the jet colormap function. No dependencies.
package dcpc_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // Position path widths, sized for the largest frame geometry allowed.
   localparam int POS_W = 12;
   localparam int EXT_W = 13;
   localparam int MAG_W = 16;
   localparam int DIFF_W = 17;

   localparam int PHASE_W = 12;
   localparam int AMP_W   = 12;
   localparam int COORD_W = 28;
   localparam int COUNT_W = 21;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PHASE_MAX     = 3'd0,
      REG_AMPLITUDE_MIN = 3'd1,
      REG_FRAME_WIDTH   = 3'd2,
      REG_CENTER_X      = 3'd3,
      REG_CENTER_Y      = 3'd4,
      REG_INV_FOCAL_X   = 3'd5,
      REG_INV_FOCAL_Y   = 3'd6,
      REG_COLOR_SCALE   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [11:0] phase_max;
      logic [11:0] amplitude_min;
      logic [10:0] frame_width;
      logic [14:0] center_x;
      logic [14:0] center_y;
      logic [23:0] inv_focal_x;
      logic [23:0] inv_focal_y;
      logic [23:0] color_scale;
   } cfg_type;

   // One kept pixel, classified by the front end.
   typedef struct packed {
      logic               neg_x;
      logic [MAG_W-1:0]   mag_x;
      logic               neg_y;
      logic [MAG_W-1:0]   mag_y;
      logic [PHASE_W-1:0] phase;
      logic [COUNT_W-1:0] count;
   } item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   function automatic rgb_type jet_color(input logic [7:0] idx);
      rgb_type c;
      logic [7:0] ramp;
      ramp = {idx[5:0], 2'b00};
      unique case (idx[7:6])
         2'd0: c = '{red: 8'd255, green: ramp, blue: 8'd0};
         2'd1: c = '{red: ~ramp, green: 8'd255, blue: 8'd0};
         2'd2: c = '{red: 8'd0, green: 8'd255, blue: ramp};
         default: c = '{red: 8'd0, green: ~ramp, blue: 8'd255};
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/dcpc_front.sv =====
// Front end: pixel position tracking, validity filter and offset magnitudes.
// Depends on dcpc_pkg.
module dcpc_front import dcpc_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               accept,
   input  logic [PHASE_W-1:0] phase,
   input  logic [AMP_W-1:0]   amplitude,
   input  logic               start_of_frame,
   output logic               item_push,
   output item_type           item
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam logic [EXT_W-1:0] WIDTH_LIMIT  = EXT_W'(MAX_WIDTH);
   localparam logic [EXT_W-1:0] HEIGHT_LIMIT = EXT_W'(MAX_HEIGHT);

   logic [CW-1:0]      col_ff, col_in, col_cur;
   logic [RW-1:0]      row_ff, row_in, row_cur;
   logic [COUNT_W-1:0] count_ff, count_in, count_cur;
   logic               keep;
   logic [EXT_W-1:0]   width_eff, col_step, row_step;
   logic signed [DIFF_W-1:0] diff_x, diff_y;

   always_comb begin
      col_cur   = start_of_frame ? '0 : col_ff;
      row_cur   = start_of_frame ? '0 : row_ff;
      count_cur = start_of_frame ? '0 : count_ff;

      keep = (phase != '0) && (phase <= cfg.phase_max) && (amplitude >= cfg.amplitude_min);

      count_in = count_cur;
      if (keep && (count_cur != COUNT_MAX)) begin
         count_in = count_cur + 1'b1;
      end

      width_eff = EXT_W'(cfg.frame_width);
      if (width_eff == '0) begin
         width_eff = EXT_W'(1);
      end else if (width_eff > WIDTH_LIMIT) begin
         width_eff = WIDTH_LIMIT;
      end

      col_step = EXT_W'(col_cur) + 1'b1;
      row_step = EXT_W'(row_cur) + 1'b1;
      col_in = col_step[CW-1:0];
      row_in = row_cur;
      if (col_step >= width_eff) begin
         col_in = '0;
         row_in = (row_step >= HEIGHT_LIMIT) ? '0 : row_step[RW-1:0];
      end

      // Offset of the principal point from the pixel, in Q.4.
      diff_x = $signed({2'b00, cfg.center_x}) - $signed({1'b0, POS_W'(col_cur), 4'b0000});
      diff_y = $signed({2'b00, cfg.center_y}) - $signed({1'b0, POS_W'(row_cur), 4'b0000});
   end

   always_comb begin
      item_push  = accept && keep;
      item.neg_x = diff_x[DIFF_W-1];
      item.mag_x = diff_x[DIFF_W-1] ? MAG_W'(-diff_x) : diff_x[MAG_W-1:0];
      item.neg_y = diff_y[DIFF_W-1];
      item.mag_y = diff_y[DIFF_W-1] ? MAG_W'(-diff_y) : diff_y[MAG_W-1:0];
      item.phase = phase;
      item.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/dcpc_queue.sv =====
// Short queue of classified points between the front and back ends.
// Depends on dcpc_pkg.
module dcpc_queue import dcpc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head_item,
   output logic     full,
   output logic     empty
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   item_type        slot_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     fill_ff, fill_in;
   logic            do_push, do_pop;

   always_comb begin
      full    = (fill_ff == (AW+1)'(QUEUE_DEPTH));
      empty   = (fill_ff == '0);
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_in   = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
      head_item = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== hw/rtl/dcpc_back.sv =====
// Back end: projection multipliers, colormap and the result register.
// Depends on dcpc_pkg.
module dcpc_back import dcpc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                queue_empty,
   input  item_type            queue_item,
   output logic                queue_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic signed [COORD_W-1:0] rsp_x_coord,
   output logic signed [COORD_W-1:0] rsp_y_coord,
   output logic [PHASE_W-1:0]  rsp_z_coord,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic [COUNT_W-1:0]  rsp_point_count
);

   localparam int P1_W = MAG_W + PHASE_W;
   localparam int P2_W = P1_W + 24;
   localparam int CP_W = PHASE_W + 24;
   localparam int Q_W  = P2_W - 24 + 1;
   localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(2**(COORD_W-1) - 1);
   localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(2**(COORD_W-1));

   logic advance;

   // Stage 1: offset times depth, and depth times color scale.
   logic               s1_valid_ff;
   logic               s1_neg_x_ff, s1_neg_y_ff;
   logic [P1_W-1:0]    s1_px_ff, s1_py_ff;
   logic [CP_W-1:0]    s1_cp_ff;
   logic [PHASE_W-1:0] s1_phase_ff;
   logic [COUNT_W-1:0] s1_count_ff;

   // Stage 2: times inverse focal length, colormap lookup.
   logic               s2_valid_ff;
   logic               s2_neg_x_ff, s2_neg_y_ff;
   logic [P2_W-1:0]    s2_px_ff, s2_py_ff;
   rgb_type            s2_rgb_ff, s2_rgb_in;
   logic [PHASE_W-1:0] s2_phase_ff;
   logic [COUNT_W-1:0] s2_count_ff;

   logic               out_valid_ff;
   logic signed [COORD_W-1:0] x_in, y_in;

   logic [CP_W-17:0]   cidx_full;
   logic [7:0]         cidx;

   function automatic logic [COORD_W-1:0] finish(input logic neg, input logic [P2_W-1:0] prod);
      logic [Q_W-1:0] q;
      logic [COORD_W-1:0] r;
      if (neg) begin
         q = Q_W'(({1'b0, prod} + (P2_W+1)'(24'hFFFFFF)) >> 24);
         r = (q > NEG_LIMIT) ? {1'b1, {(COORD_W-1){1'b0}}} : COORD_W'(-q);
      end else begin
         q = Q_W'(prod >> 24);
         r = (q > POS_LIMIT) ? {1'b0, {(COORD_W-1){1'b1}}} : q[COORD_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      advance   = !out_valid_ff || rsp_pop;
      queue_pop = advance && !queue_empty;
      cidx_full = s1_cp_ff[CP_W-1:16];
      cidx      = (cidx_full > (CP_W-16)'(255)) ? 8'd255 : cidx_full[7:0];
      s2_rgb_in = jet_color(cidx);
      x_in      = $signed(finish(s2_neg_x_ff, s2_px_ff));
      y_in      = $signed(finish(s2_neg_y_ff, s2_py_ff));
      rsp_empty = !out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !queue_empty;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_neg_x_ff <= queue_item.neg_x;
         s1_neg_y_ff <= queue_item.neg_y;
         s1_px_ff    <= P1_W'(queue_item.mag_x) * P1_W'(queue_item.phase);
         s1_py_ff    <= P1_W'(queue_item.mag_y) * P1_W'(queue_item.phase);
         s1_cp_ff    <= CP_W'(queue_item.phase) * CP_W'(cfg.color_scale);
         s1_phase_ff <= queue_item.phase;
         s1_count_ff <= queue_item.count;

         s2_neg_x_ff <= s1_neg_x_ff;
         s2_neg_y_ff <= s1_neg_y_ff;
         s2_px_ff    <= P2_W'(s1_px_ff) * P2_W'(cfg.inv_focal_x);
         s2_py_ff    <= P2_W'(s1_py_ff) * P2_W'(cfg.inv_focal_y);
         s2_rgb_ff   <= s2_rgb_in;
         s2_phase_ff <= s1_phase_ff;
         s2_count_ff <= s1_count_ff;

         rsp_x_coord     <= x_in;
         rsp_y_coord     <= y_in;
         rsp_z_coord     <= s2_phase_ff;
         rsp_red         <= s2_rgb_ff.red;
         rsp_green       <= s2_rgb_ff.green;
         rsp_blue        <= s2_rgb_ff.blue;
         rsp_point_count <= s2_count_ff;
      end
   end

endmodule

// ===== hw/rtl/depth_to_colored_point_cloud_top.sv =====
// Depth pixel stream to colored point cloud, top level; uses dcpc_pkg and the front,
// queue and back modules. A kept pixel passes the queue slot, then stage 1, stage 2
// and the result register. Throughput: one pixel per cycle while the point queue has room;
// the back end's three registered stages stall together only when the result word waits.
// Reset (synchronous, active high) empties the point queue and the back end pipeline,
// clears position and count, and loads the register defaults.
module depth_to_colored_point_cloud_top import dcpc_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [PHASE_W-1:0]        req_phase,
   input  logic [AMP_W-1:0]          req_amplitude,
   input  logic                      req_start_of_frame,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic signed [COORD_W-1:0] rsp_x_coord,
   output logic signed [COORD_W-1:0] rsp_y_coord,
   output logic [PHASE_W-1:0]        rsp_z_coord,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic [COUNT_W-1:0]        rsp_point_count,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     accept;
   logic     item_push;
   item_type item;
   item_type head_item;
   logic     queue_full, queue_empty, queue_pop;

   // Registers are always writable; software must write only while the block is idle.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_PHASE_MAX:     cfg_in.phase_max     = csr_data[11:0];
            REG_AMPLITUDE_MIN: cfg_in.amplitude_min = csr_data[11:0];
            REG_FRAME_WIDTH:   cfg_in.frame_width   = csr_data[10:0];
            REG_CENTER_X:      cfg_in.center_x      = csr_data[14:0];
            REG_CENTER_Y:      cfg_in.center_y      = csr_data[14:0];
            REG_INV_FOCAL_X:   cfg_in.inv_focal_x   = csr_data[23:0];
            REG_INV_FOCAL_Y:   cfg_in.inv_focal_y   = csr_data[23:0];
            REG_COLOR_SCALE:   cfg_in.color_scale   = csr_data[23:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_max     <= 12'd4095;
         cfg_ff.amplitude_min <= 12'd0;
         cfg_ff.frame_width   <= 11'd320;
         cfg_ff.center_x      <= 15'd2560;
         cfg_ff.center_y      <= 15'd1920;
         cfg_ff.inv_focal_x   <= 24'd67925;
         cfg_ff.inv_focal_y   <= 24'd67925;
         cfg_ff.color_scale   <= 24'd4081;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Every pixel advances the position, so the front end takes a word whenever the
   // point queue has room, whether or not the pixel turns out to be kept.
   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   dcpc_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .accept        (accept),
      .phase         (req_phase),
      .amplitude     (req_amplitude),
      .start_of_frame(req_start_of_frame),
      .item_push     (item_push),
      .item          (item)
   );

   dcpc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (item_push),
      .push_item(item),
      .pop      (queue_pop),
      .head_item(head_item),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // The back end pulls from the queue whenever its result register can move.
   dcpc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .queue_empty    (queue_empty),
      .queue_item     (head_item),
      .queue_pop      (queue_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_x_coord    (rsp_x_coord),
      .rsp_y_coord    (rsp_y_coord),
      .rsp_z_coord    (rsp_z_coord),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_point_count(rsp_point_count)
   );

   // The point queue can never report full and empty at once.
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(queue_full && queue_empty))
      else $error("point queue full and empty together");

   // Only kept pixels reach the result port: nonzero depth and count.
   a_kept_word: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_z_coord != '0) && (rsp_point_count != '0))
      else $error("result word with zero depth or zero count");

   // A word from the queue is only taken when the back end can advance.
   a_pop_guard: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_empty && (rsp_empty || rsp_pop))
      else $error("point queue popped while back end stalled");

   // Reset leaves no result word pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result word present after reset");

endmodule

// ===== tb/point_cloud_scoreboard.sv =====
// Scoreboard package for the depth to colored point cloud testbench: a predictor of
// the block's points and the store of points still awaited on the result ports.
// Depends on dcpc_pkg for widths and register indexes.
`timescale 1ns / 100ps

package point_cloud_sb_pkg;
   import dcpc_pkg::*;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic [PHASE_W-1:0]        z_coord;
      logic [7:0]                red;
      logic [7:0]                green;
      logic [7:0]                blue;
      logic [COUNT_W-1:0]        point_count;
   } cloud_point_type;

   class point_cloud_scoreboard;
      logic [11:0] phase_max;
      logic [11:0] amplitude_min;
      logic [10:0] frame_width;
      logic [14:0] center_x;
      logic [14:0] center_y;
      logic [23:0] inv_focal_x;
      logic [23:0] inv_focal_y;
      logic [23:0] color_scale;
      int unsigned column;
      int unsigned row;
      int unsigned kept;
      cloud_point_type awaited_points[$];
      int unsigned errors;

      function new();
         phase_max     = 12'd4095;
         amplitude_min = 12'd0;
         frame_width   = 11'd320;
         center_x      = 15'd2560;
         center_y      = 15'd1920;
         inv_focal_x   = 24'd67925;
         inv_focal_y   = 24'd67925;
         color_scale   = 24'd4081;
         column  = 0;
         row     = 0;
         kept    = 0;
         errors  = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_PHASE_MAX:     phase_max     = data[11:0];
            REG_AMPLITUDE_MIN: amplitude_min = data[11:0];
            REG_FRAME_WIDTH:   frame_width   = data[10:0];
            REG_CENTER_X:      center_x      = data[14:0];
            REG_CENTER_Y:      center_y      = data[14:0];
            REG_INV_FOCAL_X:   inv_focal_x   = data;
            REG_INV_FOCAL_Y:   inv_focal_y   = data;
            REG_COLOR_SCALE:   color_scale   = data;
            default: ;
         endcase
      endfunction

      // Back-projection of one axis: (center - 16*pos) * z * inv / 2^24, floored,
      // saturated to the signed coordinate range.
      function logic signed [COORD_W-1:0] back_project(logic [14:0] center,
            int unsigned pos, logic [PHASE_W-1:0] z, logic [23:0] inv);
         longint diff;
         longint unsigned mag;
         longint unsigned prod;
         longint unsigned q;
         diff = longint'(center) - longint'(pos) * 16;
         mag = (diff < 0) ? -diff : diff;
         prod = mag * z * inv;
         if (diff < 0) begin
            // Flooring a negative value rounds its magnitude up.
            q = (prod + 64'hFF_FFFF) >> 24;
            if (q > 64'd134217728)
               return {1'b1, {(COORD_W-1){1'b0}}};
            return COORD_W'(-longint'(q));
         end
         q = prod >> 24;
         if (q > 64'd134217727)
            return {1'b0, {(COORD_W-1){1'b1}}};
         return COORD_W'(q);
      endfunction

      function void note_pixel(logic [PHASE_W-1:0] phase, logic [AMP_W-1:0] amplitude,
            logic sof);
         longint unsigned color_index;
         int unsigned width;
         int unsigned i;
         cloud_point_type pt;
         if (sof) begin
            column = 0;
            row    = 0;
            kept   = 0;
         end
         width = frame_width;
         if (width < 1) width = 1;
         if (width > DEF_MAX_WIDTH) width = DEF_MAX_WIDTH;
         if (phase != 0 && phase <= phase_max && amplitude >= amplitude_min) begin
            color_index = (64'(phase) * 64'(color_scale)) >> 16;
            i = (color_index > 255) ? 255 : int'(color_index);
            if (kept < 2097151) kept++;
            pt.x_coord = back_project(center_x, column, phase, inv_focal_x);
            pt.y_coord = back_project(center_y, row, phase, inv_focal_y);
            pt.z_coord = phase;
            if (i < 64) begin
               pt.red = 8'd255;  pt.green = 8'(4 * i);  pt.blue = 8'd0;
            end else if (i < 128) begin
               pt.red = 8'(255 - 4 * (i - 64));  pt.green = 8'd255;  pt.blue = 8'd0;
            end else if (i < 192) begin
               pt.red = 8'd0;  pt.green = 8'd255;  pt.blue = 8'(4 * (i - 128));
            end else begin
               pt.red = 8'd0;  pt.green = 8'(255 - 4 * (i - 192));  pt.blue = 8'd255;
            end
            pt.point_count = COUNT_W'(kept);
            awaited_points.push_back(pt);
         end
         column++;
         if (column >= width) begin
            column = 0;
            row++;
            if (row >= DEF_MAX_HEIGHT) row = 0;
         end
      endfunction

      function void compare(string field, longint want, longint got);
         if (want == got) return;
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_point(cloud_point_type got);
         cloud_point_type want;
         if (awaited_points.size() == 0) begin
            errors++;
            $display("%0t: point with nothing awaited, expected none, actual x %0d y %0d z %0d",
                     $time, got.x_coord, got.y_coord, got.z_coord);
            return;
         end
         want = awaited_points.pop_front();
         compare("x_coord", want.x_coord, got.x_coord);
         compare("y_coord", want.y_coord, got.y_coord);
         compare("z_coord", want.z_coord, got.z_coord);
         compare("red", want.red, got.red);
         compare("green", want.green, got.green);
         compare("blue", want.blue, got.blue);
         compare("point_count", want.point_count, got.point_count);
      endfunction

      function int pending();
         return awaited_points.size();
      endfunction
   endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench for depth_to_colored_point_cloud_top: drives pixel words and
// register writes, drains point words and checks them against the scoreboard.
// Depends on dcpc_pkg and point_cloud_sb_pkg.
`timescale 1ns / 100ps

module testbench import dcpc_pkg::*, point_cloud_sb_pkg::*;;

   // A run ends early if no word of any kind moves for this many cycles.
   localparam int WATCHDOG_LIMIT = 1000;
   // A pixel passes the point queue and the back end registers to become a point; a dropped pixel
   // shows up nowhere, so register writes wait this long after the last point.
   localparam int DRAIN_CYCLES = 8;

   logic                      clock;
   logic                      reset;
   logic                      req_push;
   logic                      req_full;
   logic [PHASE_W-1:0]        req_phase;
   logic [AMP_W-1:0]          req_amplitude;
   logic                      req_start_of_frame;
   logic                      rsp_empty;
   logic                      rsp_pop;
   logic signed [COORD_W-1:0] rsp_x_coord;
   logic signed [COORD_W-1:0] rsp_y_coord;
   logic [PHASE_W-1:0]        rsp_z_coord;
   logic [7:0]                rsp_red;
   logic [7:0]                rsp_green;
   logic [7:0]                rsp_blue;
   logic [COUNT_W-1:0]        rsp_point_count;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;

   // Percent chance per word that a side starts an idle burst; zero means a
   // stretch with no idling at all.
   int unsigned send_stall_pct = 0;
   int unsigned pop_stall_pct = 0;
   int unsigned pop_stall_left = 0;

   point_cloud_scoreboard sb;

   depth_to_colored_point_cloud_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_phase          (req_phase),
      .req_amplitude      (req_amplitude),
      .req_start_of_frame (req_start_of_frame),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_x_coord        (rsp_x_coord),
      .rsp_y_coord        (rsp_y_coord),
      .rsp_z_coord        (rsp_z_coord),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_point_count    (rsp_point_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // All handshakes are observed here, at the rising edge, before the block's
   // registers move. A point word is checked before a pixel word of the same
   // cycle is noted, although either order gives the same result.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty)
            sb.check_point('{x_coord: rsp_x_coord, y_coord: rsp_y_coord,
                             z_coord: rsp_z_coord, red: rsp_red, green: rsp_green,
                             blue: rsp_blue, point_count: rsp_point_count});
         if (req_push && !req_full)
            sb.note_pixel(req_phase, req_amplitude, req_start_of_frame);
         if (csr_valid && csr_ready)
            sb.write_reg(reg_index_type'(csr_index), csr_data);
      end
   end

   // The result side pops at every falling edge unless it is in an idle burst.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (pop_stall_left != 0) begin
            rsp_pop = 1'b0;
            pop_stall_left--;
         end else if (pop_stall_pct != 0 && $urandom_range(0, 99) < pop_stall_pct) begin
            rsp_pop = 1'b0;
            pop_stall_left = $urandom_range(0, 10);
         end else begin
            rsp_pop = 1'b1;
         end
      end
   end

   // The watchdog only counts cycles in which no word moves on any port.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the pixel word
   // has been taken.
   task automatic send_pixel(logic [PHASE_W-1:0] phase, logic [AMP_W-1:0] amplitude,
         logic sof);
      if (send_stall_pct != 0 && $urandom_range(0, 99) < send_stall_pct) begin
         req_push = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_push           = 1'b1;
      req_phase          = phase;
      req_amplitude      = amplitude;
      req_start_of_frame = sof;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      req_push = 1'b0;
   endtask

   task automatic program_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Registers may only change with the pipeline empty, including any dropped
   // pixel still on its way through.
   task automatic settle();
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic int unsigned pick(int unsigned lo, int unsigned hi);
      case ($urandom_range(0, 3))
         0: return lo;
         1: return hi;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   // Narrow registers sometimes get garbage above their width, which the block
   // has to ignore.
   function automatic logic [CSR_DATA_W-1:0] with_junk(int unsigned value, int unsigned bits);
      logic [31:0] junk;
      junk = 32'($urandom) << bits;
      if ($urandom_range(0, 3) == 0)
         return CSR_DATA_W'(value) | junk[CSR_DATA_W-1:0];
      return CSR_DATA_W'(value);
   endfunction

   initial begin
      int unsigned ph;
      int unsigned k;
      int unsigned n;
      bit long_row;
      logic [PHASE_W-1:0] p;
      logic [AMP_W-1:0] a;
      logic sof;

      sb = new();
      reset              = 1'b1;
      req_push           = 1'b0;
      req_phase          = '0;
      req_amplitude      = '0;
      req_start_of_frame = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = REG_PHASE_MAX;
      csr_data           = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. A color scale of exactly one makes the color index
      // equal to the phase, so each jet segment edge can be hit by name.
      // The three-pixel row makes the column wrap early.
      program_reg(REG_PHASE_MAX, 24'd3000);
      program_reg(REG_AMPLITUDE_MIN, 24'd100);
      program_reg(REG_FRAME_WIDTH, 24'd3);
      program_reg(REG_COLOR_SCALE, 24'd65536);
      send_pixel(12'd1, 12'd100, 1'b1);
      send_pixel(12'd63, 12'd4095, 1'b0);
      send_pixel(12'd64, 12'd200, 1'b0);
      send_pixel(12'd127, 12'd4095, 1'b0);
      send_pixel(12'd128, 12'd100, 1'b0);
      send_pixel(12'd191, 12'd100, 1'b0);
      send_pixel(12'd192, 12'd100, 1'b0);
      send_pixel(12'd255, 12'd100, 1'b0);
      // Phase at the limit is kept and its index clamps at the top of the map.
      send_pixel(12'd3000, 12'd100, 1'b0);
      // Over the phase limit, zero phase and one short of the amplitude floor
      // are all dropped.
      send_pixel(12'd3001, 12'd100, 1'b0);
      send_pixel(12'd0, 12'd4095, 1'b0);
      send_pixel(12'd500, 12'd99, 1'b0);
      // A dropped pixel that starts a frame must still clear position and count.
      send_pixel(12'd4095, 12'd100, 1'b1);
      send_pixel(12'd2000, 12'd2000, 1'b0);
      // Start of frame in the middle of a row, on a kept pixel.
      send_pixel(12'd10, 12'd100, 1'b1);

      // Hold the sender until every point is out before anything else moves.
      wait_drained();
      settle();

      // Width zero behaves as one, so every pixel starts a new row. The color
      // scale is far too large and the focal reciprocals are at full scale.
      program_reg(REG_FRAME_WIDTH, 24'd0);
      program_reg(REG_PHASE_MAX, 24'd4095);
      program_reg(REG_AMPLITUDE_MIN, 24'd0);
      program_reg(REG_COLOR_SCALE, 24'hFF_FFFF);
      program_reg(REG_CENTER_X, 24'd0);
      program_reg(REG_CENTER_Y, 24'd32767);
      program_reg(REG_INV_FOCAL_X, 24'hFF_FFFF);
      program_reg(REG_INV_FOCAL_Y, 24'hFF_FFFF);
      send_pixel(12'd4095, 12'd0, 1'b1);
      send_pixel(12'd4095, 12'd4095, 1'b0);
      send_pixel(12'd1, 12'd0, 1'b0);
      send_pixel(12'd2048, 12'd2048, 1'b0);
      send_pixel(12'd0, 12'd0, 1'b1);
      send_pixel(12'd1365, 12'd2730, 1'b0);

      // Random part. Each phase draws a fresh register set and a traffic shape.
      // Phase 3 runs more than a full frame height of one-pixel rows so the row
      // counter wraps; phase 7 asks for an oversized width, which is clamped to
      // the widest row. The last phase runs with no idling on either side.
      for (ph = 0; ph < 12; ph++) begin
         settle();
         long_row = (ph == 3);
         if (ph == 11) begin
            send_stall_pct = 0;
            pop_stall_pct  = 0;
         end else begin
            send_stall_pct = $urandom_range(0, 2) * 10;
            pop_stall_pct  = $urandom_range(0, 3) * 8;
         end
         program_reg(REG_PHASE_MAX,
                     with_junk(($urandom_range(0, 2) != 0) ? 4095 : pick(0, 4095), 12));
         program_reg(REG_AMPLITUDE_MIN,
                     with_junk(($urandom_range(0, 2) != 0) ? $urandom_range(0, 300)
                                                           : pick(0, 4095), 12));
         if (ph == 3)
            program_reg(REG_FRAME_WIDTH, 24'd1);
         else if (ph == 7)
            program_reg(REG_FRAME_WIDTH, 24'd2047);
         else
            program_reg(REG_FRAME_WIDTH,
                        with_junk(($urandom_range(0, 4) == 0) ? pick(0, 2047)
                                                              : $urandom_range(1, 8), 11));
         program_reg(REG_CENTER_X, with_junk(pick(0, 32767), 15));
         program_reg(REG_CENTER_Y, with_junk(pick(0, 32767), 15));
         program_reg(REG_INV_FOCAL_X,
                     ($urandom_range(0, 9) == 0) ? 24'd0 : CSR_DATA_W'(pick(1, 24'hFF_FFFF)));
         program_reg(REG_INV_FOCAL_Y,
                     ($urandom_range(0, 9) == 0) ? 24'd0 : CSR_DATA_W'(pick(1, 24'hFF_FFFF)));
         program_reg(REG_COLOR_SCALE,
                     ($urandom_range(0, 1) != 0) ? CSR_DATA_W'($urandom_range(0, 20000))
                                                 : CSR_DATA_W'(pick(0, 24'hFF_FFFF)));

         n = long_row ? 1026 : 4 + $urandom_range(0, 6);
         for (k = 0; k < n; k++) begin
            sof = (k == 0) || (!long_row && $urandom_range(0, 49) == 0);
            // Phases cluster at the acceptance limits and inside the window.
            case ($urandom_range(0, 19))
               0: p = '0;
               1: p = sb.phase_max;
               2: p = (sb.phase_max < 12'd4095) ? sb.phase_max + 12'd1 : 12'd4095;
               3: p = 12'd4095;
               4, 5: p = $urandom_range(0, 4095);
               default: p = (sb.phase_max == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(1, sb.phase_max);
            endcase
            case ($urandom_range(0, 9))
               0: a = sb.amplitude_min;
               1: a = sb.amplitude_min - 12'd1;
               2: a = $urandom_range(0, 4095);
               default: a = $urandom_range(sb.amplitude_min, 4095);
            endcase
            send_pixel(p, a, sof);
            if (ph != 11 && $urandom_range(0, 99) == 0)
               wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
